@@ rtl/core/isc_pkg.sv @@
// Shared types and constants for the inverse sum-of-cubes block.
package isc_pkg;

  // Fixed field widths of the item ports
  localparam int TOTAL_WIDTH = 64;
  localparam int COUNT_WIDTH = 17;

  // Default number of total bits that take part
  localparam int DEF_INPUT_WIDTH = 64;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT1,
    ST_SETUP2,
    ST_ROOT2,
    ST_FINISH
  } isc_state_t;

endpackage

@@ rtl/core/inverse_sum_of_cubes.sv @@
// Top level: decides whether total is 1^3 + ... + n^3 and returns n.
//
// One item enters, then a restoring square-root unit that finds one result
// bit per cycle runs twice: first on total (k = isqrt(total), must be exact),
// then on 8k+1 (s = isqrt(8k+1), must be exact). An exact second root gives
// n = (s-1)/2. A setup state sits between the passes and a finish state
// follows them. The root unit is the only arithmetic; it sets the rate. The
// input stalls while an item is at work, so a new item is accepted only once
// the last has left its finish state; the result sits in an output register
// until taken, and a finished item waits in its finish state only if an
// earlier result has still not been taken. Bits of total above INPUT_WIDTH
// are ignored. Zero total reports found with n = 0; any other non-sum reports
// found = 0 and count = 0.
module inverse_sum_of_cubes #(
  parameter int INPUT_WIDTH = isc_pkg::DEF_INPUT_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             total_valid,
  output logic                             total_stall,
  input  logic [isc_pkg::TOTAL_WIDTH-1:0]  total,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic                             found,
  output logic [isc_pkg::COUNT_WIDTH-1:0]  count
);
  import isc_pkg::*;

  // Root widths of the two passes; the shared unit is sized for the wider
  localparam int RW1    = (INPUT_WIDTH + 1) / 2;
  localparam int RW2    = (RW1 + 4) / 2;
  localparam int RWM    = (RW1 > RW2) ? RW1 : RW2;
  localparam int OPW    = 2 * RWM;
  localparam int REMW   = RWM + 2;
  localparam int STEP_W = $clog2(RWM);

  isc_state_t state, state_next;

  logic [OPW-1:0]    op;
  logic [REMW-1:0]   rem;
  logic [RWM-1:0]    root;
  logic [STEP_W-1:0] cnt;
  logic              zero;
  logic              ok1;

  logic              accept;
  logic              step_en;
  logic              setup2;
  logic              finish;
  logic              slot_free;
  logic              last_step;

  logic [REMW-1:0]   rem_shift;
  logic [REMW-1:0]   trial;
  logic              ge;
  logic [REMW-1:0]   rem_next;
  logic [RWM-1:0]    root_next;
  logic              found_next;
  logic [COUNT_WIDTH-1:0] count_next;

  assign slot_free = !result_valid || !result_stall;
  assign last_step = (cnt == '0);
  assign accept    = total_valid && !total_stall;

  // Next state of the sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (total_valid) state_next = ST_ROOT1;
      ST_ROOT1:  if (last_step) state_next = ST_SETUP2;
      ST_SETUP2: state_next = ST_ROOT2;
      ST_ROOT2:  if (last_step) state_next = ST_FINISH;
      ST_FINISH: if (slot_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    total_stall = 1'b1;
    step_en     = 1'b0;
    setup2      = 1'b0;
    finish      = 1'b0;
    case (state)
      ST_IDLE:   total_stall = 1'b0;
      ST_ROOT1:  step_en = 1'b1;
      ST_SETUP2: setup2 = 1'b1;
      ST_ROOT2:  step_en = 1'b1;
      ST_FINISH: finish = slot_free;
      default:   total_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // One restoring root step: bring down two operand bits, try root*4+1
  always_comb begin
    rem_shift = {rem[RWM-1:0], op[OPW-1 -: 2]};
    trial     = {root, 2'b01};
    ge        = (rem_shift >= trial);
    rem_next  = ge ? (rem_shift - trial) : rem_shift;
    root_next = {root[RWM-2:0], ge};
  end

  // Final decision: an exact odd root s of 8k+1 gives n = s >> 1
  always_comb begin
    found_next = zero || (ok1 && (rem == '0));
    count_next = '0;
    if (!zero && found_next) begin
      count_next = COUNT_WIDTH'(root >> 1);
    end
  end

  // Root datapath: load, iterate, reload for the second pass
  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= OPW'(total[INPUT_WIDTH-1:0]);
      rem  <= '0;
      root <= '0;
      cnt  <= STEP_W'(RWM - 1);
      zero <= (total[INPUT_WIDTH-1:0] == '0);
    end else if (step_en) begin
      op   <= op << 2;
      rem  <= rem_next;
      root <= root_next;
      cnt  <= cnt - 1'b1;
    end else if (setup2) begin
      op   <= OPW'({root, 3'b001});
      ok1  <= (rem == '0);
      rem  <= '0;
      root <= '0;
      cnt  <= STEP_W'(RWM - 1);
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      found <= found_next;
      count <= count_next;
    end
  end

  // A rejected total never carries a count
  a_no_count_when_absent: assert property (@(posedge clk) disable iff (rst)
    result_valid && !found |-> count == '0)
    else $error("count set on a result that was not found");

  // An exact second root is always odd, since 8k+1 is odd
  a_odd_root: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && !zero && ok1 && rem == '0 |-> root[0])
    else $error("exact root of 8k+1 is even");

  // An accepted item starts a full first pass
  a_start_pass: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_ROOT1 && cnt == STEP_W'(RWM - 1))
    else $error("first root pass did not start after accept");

  // The second pass always ends in the finish state
  a_pass_end: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROOT2 && last_step |=> state == ST_FINISH)
    else $error("second root pass did not reach finish");

endmodule

@@ bench/inverse_sum_of_cubes_tb.sv @@
// Testbench for inverse_sum_of_cubes: directed and random totals against an in-bench predictor.
`timescale 1ns / 1ps

module inverse_sum_of_cubes_tb;

  localparam int INPUT_WIDTH = isc_pkg::DEF_INPUT_WIDTH;
  localparam logic [63:0] TOTAL_MASK = {64{1'b1}} >> (64 - INPUT_WIDTH);
  // Largest n whose sum of cubes still fits in 64 bits
  localparam int MAX_COUNT = 92681;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 100;

  typedef struct packed {
    logic                            found;
    logic [isc_pkg::COUNT_WIDTH-1:0] count;
  } cube_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            total_valid = 1'b0;
  logic                            total_stall;
  logic [isc_pkg::TOTAL_WIDTH-1:0] total = '0;
  logic                            result_valid;
  logic                            result_stall = 1'b0;
  logic                            found;
  logic [isc_pkg::COUNT_WIDTH-1:0] count;

  cube_result_t pending_results[$];
  bit           no_idle = 1'b0;
  int           errors = 0;
  int           totals_sent = 0;
  int           results_checked = 0;
  int           sums_found = 0;
  int           stall_left = 0;
  int           idle_cycles = 0;

  inverse_sum_of_cubes #(
    .INPUT_WIDTH(INPUT_WIDTH)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .total_valid (total_valid),
    .total_stall (total_stall),
    .total       (total),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .found       (found),
    .count       (count)
  );

  always #5 clk = ~clk;

  // Exact floor square root, one result bit per step from the top
  function automatic logic [63:0] floor_sqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  // Expected result for one total
  function automatic cube_result_t cube_count_of(input logic [63:0] t);
    logic [63:0] m;
    logic [63:0] k;
    logic [63:0] d;
    logic [63:0] s;
    logic [63:0] n;
    cube_result_t res;
    res = '0;
    m = t & TOTAL_MASK;
    if (m == 64'd0) begin
      res.found = 1'b1;
      return res;
    end
    k = floor_sqrt64(m);
    if (k * k != m) return res;
    d = 64'd1 + (k << 3);
    s = floor_sqrt64(d);
    if (s * s != d || !s[0]) return res;
    n = (s - 64'd1) >> 1;
    if (n != 64'd0 && ((n * (n + 64'd1)) >> 1) == k) begin
      res.found = 1'b1;
      res.count = n[isc_pkg::COUNT_WIDTH-1:0];
    end
    return res;
  endfunction

  function automatic logic [63:0] cube_sum(input logic [63:0] n);
    logic [63:0] tri_num;
    tri_num = (n * (n + 64'd1)) >> 1;
    return tri_num * tri_num;
  endfunction

  function automatic logic [63:0] random_total();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] random_count();
    // Favor small n, but reach the top of the range too
    if ($urandom_range(0, 2) == 0) return 64'($urandom_range(1, 200));
    return 64'($urandom_range(1, MAX_COUNT));
  endfunction

  // Send one item, with an optional idle burst ahead of it
  task automatic send_total(input logic [63:0] v);
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      total_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    total_valid <= 1'b1;
    total       <= v;
    do @(posedge clk); while (total_stall);
    pending_results.push_back(cube_count_of(v));
    totals_sent++;
  endtask

  // Hold the input channel idle
  task automatic drop_valid();
    @(negedge clk);
    total_valid <= 1'b0;
  endtask

  // Stall the result channel in random bursts
  always @(negedge clk) begin
    if (no_idle) begin
      stall_left   = 0;
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left   = $urandom_range(0, 4);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    cube_result_t exp_res;
    if (!rst && result_valid && !result_stall) begin
      results_checked++;
      if (found) sums_found++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result found=%0d count=%0d", $time, found, count);
      end else begin
        exp_res = pending_results.pop_front();
        if (found !== exp_res.found) begin
          errors++;
          $display("%0t: found expected %0d actual %0d", $time, exp_res.found, found);
        end
        if (count !== exp_res.count) begin
          errors++;
          $display("%0t: count expected %0d actual %0d", $time, exp_res.count, count);
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (total_valid && !total_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Edges of the range and the named special cases
  task automatic test_corner_values();
    send_total(64'd0);
    send_total(64'd1);
    send_total(64'd9);
    send_total(64'd36);
    send_total(64'd100);
    send_total(64'd2);
    send_total(64'd4);
    send_total(64'd64);
    send_total(64'd8);
    send_total(cube_sum(64'(MAX_COUNT)));
    send_total(cube_sum(64'(MAX_COUNT)) - 64'd1);
    send_total(cube_sum(64'(MAX_COUNT)) + 64'd1);
    send_total({64{1'b1}});
    send_total(64'd1 << 63);
    send_total({32'd0, {32{1'b1}}} * {32'd0, {32{1'b1}}});
    send_total(64'hAAAA_AAAA_AAAA_AAAA);
    send_total(64'h5555_5555_5555_5555);
    send_total(cube_sum(64'd65536));
    send_total(cube_sum(64'd2) + 64'd1);
    send_total(cube_sum(64'd10) - 64'd1);
  endtask

  // Well-formed sums with random n
  task automatic test_cube_sums(input int items);
    repeat (items) send_total(cube_sum(random_count()));
  endtask

  // Perfect squares that miss, and sums nudged off by a little
  task automatic test_near_misses(input int items);
    logic [63:0] k;
    logic [63:0] base;
    repeat (items) begin
      case ($urandom_range(0, 2))
        0: begin
          k = 64'($urandom);
          send_total(k * k);
        end
        1: begin
          k = (random_count() * (random_count() + 64'd1)) >> 1;
          k = 64'(k[31:0]) + (($urandom_range(0, 1) == 0) ? 64'd1 : -64'd1);
          send_total(64'(k[31:0]) * 64'(k[31:0]));
        end
        default: begin
          base = cube_sum(random_count());
          send_total(base + 64'($signed($urandom_range(0, 16)) - 8));
        end
      endcase
    end
  endtask

  // Plain noise over the whole field
  task automatic test_random_totals(input int items);
    repeat (items) begin
      if ($urandom_range(0, 3) == 0) send_total(64'($urandom_range(0, 5000)));
      else send_total(random_total());
    end
  endtask

  // Mixed items with both sides running flat out
  task automatic test_back_to_back(input int items);
    no_idle = 1'b1;
    repeat (items) begin
      if ($urandom_range(0, 1) == 0) send_total(cube_sum(random_count()));
      else send_total(random_total());
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    test_corner_values();
    test_cube_sums(400);
    test_near_misses(300);
    test_random_totals(250);
    test_back_to_back(250);
    drop_valid();

    // Drain outstanding results, then watch for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("summary: %0d totals sent, %0d results checked, %0d reported as sums of cubes",
             totals_sent, results_checked, sums_found);
    $display("summary: corners, random sums, near misses, noise and back-to-back traffic");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/isc_pkg.sv
rtl/core/inverse_sum_of_cubes.sv
bench/inverse_sum_of_cubes_tb.sv
